[src/hbu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbu_pkg
// Shared types and constants for the 2x bilinear height grid upsampler.
// ----------------------------------------------------------------------------
package hbu_pkg;

   // register indexes of the configuration port
   localparam logic CSR_ROW_LENGTH    = 1'b0;
   localparam logic CSR_ROWS_IN_FRAME = 1'b1;

   // field widths
   localparam int SAMPLE_W = 16;
   localparam int VALUE_W  = 18;
   localparam int OROW_W   = 13;
   localparam int OCOL_W   = 8;
   localparam int ROWCNT_W = 12;
   localparam int COLPOS_W = 7;
   localparam int CSR_W    = 13;

   // result slots of one sample, in delivery order
   localparam int SLOT_VMID = 0;
   localparam int SLOT_CTR  = 1;
   localparam int SLOT_HMID = 2;
   localparam int SLOT_SELF = 3;

   // one sample's worth of results, handed to the result sequencer
   typedef struct packed {
      logic [ROWCNT_W-1:0]       row;
      logic [COLPOS_W-1:0]       col;
      logic [3:0]                mask;
      logic signed [VALUE_W-1:0] v_mid;
      logic signed [VALUE_W-1:0] ctr;
      logic signed [VALUE_W-1:0] h_mid;
      logic signed [VALUE_W-1:0] self_val;
   } hbu_item_type;

endpackage

[src/hbu_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hbu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port, holds when not reading
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[src/hbu_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbu_emit
// Result sequencer: holds the results of one sample and, unless stalled, sends
// them one per cycle: vertical midpoint, centre, horizontal midpoint, sample.
// ----------------------------------------------------------------------------
module hbu_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_valid,
   output logic                 load_ready,
   input  hbu_pkg::hbu_item_type load_item,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata,   // out_row[12:0], out_col[20:13],
                                             // height_value[38:21], zero[39]
   output logic                 rsp_tlast
);
   import hbu_pkg::*;

   hbu_item_type            item_ff;
   logic [3:0]              mask_ff;
   logic [3:0]              mask_in;
   logic [3:0]              low_bit;
   logic                    take;
   logic [OROW_W-1:0]       row_even;
   logic [OROW_W-1:0]       row_odd;
   logic [OCOL_W-1:0]       col_even;
   logic [OCOL_W-1:0]       col_odd;
   logic [OROW_W-1:0]       out_row;
   logic [OCOL_W-1:0]       out_col;
   logic signed [VALUE_W-1:0] out_val;

   // pending results and handshake
   assign take       = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (mask_ff != 4'b0000);
   assign rsp_tlast  = (mask_ff == 4'b1000);
   assign load_ready = !rsp_tvalid || (rsp_tlast && rsp_tready);
   assign low_bit    = mask_ff & (~mask_ff + 4'b0001);

   always_comb begin
      mask_in = mask_ff;
      if (take) begin
         mask_in = mask_ff & ~low_bit;
      end
      if (load_valid && load_ready) begin
         mask_in = load_item.mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= 4'b0000;
      end else begin
         mask_ff <= mask_in;
      end
   end

   // item payload, no reset needed
   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         item_ff <= load_item;
      end
   end

   // coordinates of the grid points around this sample
   assign row_even = {item_ff.row, 1'b0};
   assign row_odd  = row_even - OROW_W'(1);
   assign col_even = {item_ff.col, 1'b0};
   assign col_odd  = col_even - OCOL_W'(1);

   // pick the earliest pending result
   always_comb begin
      out_row = row_even;
      out_col = col_even;
      out_val = item_ff.self_val;
      if (low_bit[SLOT_VMID]) begin
         out_row = row_odd;
         out_val = item_ff.v_mid;
      end else if (low_bit[SLOT_CTR]) begin
         out_row = row_odd;
         out_col = col_odd;
         out_val = item_ff.ctr;
      end else if (low_bit[SLOT_HMID]) begin
         out_col = col_odd;
         out_val = item_ff.h_mid;
      end
   end

   assign rsp_tdata = {1'b0, out_val, out_col, out_row};

endmodule

[src/heightmap_bilinear_upsample_2x.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_bilinear_upsample_2x
// Streaming 2x bilinear upsampler for a raster-order height grid.
// Path: an accepted sample is registered in stage one, then loaded into the
// result sequencer, whose register offers the sample's first result.
// Throughput: one result per cycle while rsp_tready is high; a sample causes 1
// to 4 results, and the single result port sets the rate.
// Reset: synchronous; counters and neighbor samples clear, registers return
// to 101; the previous-row RAM is not cleared (row 0 never uses it).
// ----------------------------------------------------------------------------
module heightmap_bilinear_upsample_2x #(
   parameter int MAX_ROW_LENGTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // height_sample[15:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // out_row[12:0], out_col[20:13],
                                     // height_value[38:21], zero[39]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [12:0] csr_wdata
);
   import hbu_pkg::*;

   localparam int EFF_LEN   = (MAX_ROW_LENGTH < 128) ? MAX_ROW_LENGTH : 128;
   localparam int AW        = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
   localparam int CW        = $clog2(EFF_LEN);
   localparam int LEN_RESET = (EFF_LEN < 101) ? EFF_LEN : 101;

   logic [7:0]            len_ff;
   logic [CSR_W-1:0]      rows_ff;
   logic [CW-1:0]         col_ff;
   logic [ROWCNT_W-1:0]   row_ff;
   logic [CW-1:0]         col_in;
   logic [ROWCNT_W-1:0]   row_in;
   logic                  s1_valid_ff;
   logic [SAMPLE_W-1:0]   s1_sample_ff;
   logic [CW-1:0]         s1_col_ff;
   logic [ROWCNT_W-1:0]   s1_row_ff;
   logic [SAMPLE_W-1:0]   left_ff;
   logic [SAMPLE_W-1:0]   ul_ff;
   logic [SAMPLE_W-1:0]   up_word;
   logic                  accept;
   logic                  advance;
   logic                  emit_ready;
   logic                  col_wrap;
   logic                  row_wrap;
   hbu_item_type          item;
   logic signed [VALUE_W-1:0] cur_x;
   logic signed [VALUE_W-1:0] up_x;
   logic signed [VALUE_W-1:0] left_x;
   logic signed [VALUE_W-1:0] ul_x;

   // configuration registers, stored already clamped
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= 8'(LEN_RESET);
         rows_ff <= CSR_W'(101);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROW_LENGTH: begin
               if (csr_wdata[7:0] < 8'd2) begin
                  len_ff <= 8'd2;
               end else if (32'(csr_wdata[7:0]) > EFF_LEN) begin
                  len_ff <= 8'(EFF_LEN);
               end else begin
                  len_ff <= csr_wdata[7:0];
               end
            end
            CSR_ROWS_IN_FRAME: begin
               if (csr_wdata < CSR_W'(2)) begin
                  rows_ff <= CSR_W'(2);
               end else if (csr_wdata > CSR_W'(4096)) begin
                  rows_ff <= CSR_W'(4096);
               end else begin
                  rows_ff <= csr_wdata;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // handshake: stage one moves when the sequencer can take its results
   assign advance    = s1_valid_ff && emit_ready;
   assign req_tready = !s1_valid_ff || emit_ready;
   assign accept     = req_tvalid && req_tready;

   // grid position of the next sample
   assign col_wrap = (9'(col_ff) + 9'd1) >= {1'b0, len_ff};
   assign row_wrap = (13'(row_ff) + 13'd1) >= rows_ff;

   always_comb begin
      col_in = col_ff + CW'(1);
      row_in = row_ff;
      if (col_wrap) begin
         col_in = '0;
         row_in = row_wrap ? '0 : row_ff + ROWCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // stage one: sample waits here while the row above is read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_tdata;
         s1_col_ff    <= col_ff;
         s1_row_ff    <= row_ff;
      end
   end

   // previous row store: read on accept, written back as the sample moves on
   hbu_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(MAX_ROW_LENGTH)
   ) u_row_ram (
      .clock(clock),
      .we   (advance),
      .waddr(AW'(s1_col_ff)),
      .wdata(s1_sample_ff),
      .re   (accept),
      .raddr(AW'(col_ff)),
      .rdata(up_word)
   );

   // left and upper-left neighbors
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         ul_ff   <= '0;
      end else if (advance) begin
         left_ff <= s1_sample_ff;
         ul_ff   <= up_word;
      end
   end

   // quarter-unit results of this sample
   assign cur_x  = VALUE_W'(signed'(s1_sample_ff));
   assign up_x   = VALUE_W'(signed'(up_word));
   assign left_x = VALUE_W'(signed'(left_ff));
   assign ul_x   = VALUE_W'(signed'(ul_ff));

   always_comb begin
      item.row            = s1_row_ff;
      item.col            = COLPOS_W'(s1_col_ff);
      item.mask[SLOT_VMID] = (s1_row_ff != '0);
      item.mask[SLOT_CTR]  = (s1_row_ff != '0) && (s1_col_ff != '0);
      item.mask[SLOT_HMID] = (s1_col_ff != '0);
      item.mask[SLOT_SELF] = 1'b1;
      item.v_mid          = (up_x + cur_x) <<< 1;
      item.ctr            = (ul_x + up_x) + (left_x + cur_x);
      item.h_mid          = (left_x + cur_x) <<< 1;
      item.self_val       = cur_x <<< 2;
   end

   hbu_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load_valid(s1_valid_ff),
      .load_ready(emit_ready),
      .load_item (item),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   // a sample handed on always shows up at the result port next cycle
   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("results of a moved sample not offered");

   // the read of the next sample never hits the entry being written back
   a_no_ram_clash: assert property (@(posedge clock) disable iff (reset)
      (accept && advance) |-> (col_ff != s1_col_ff))
      else $error("row store read and write to the same entry");

   // a stalled stage one keeps its sample
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !emit_ready) |=> (s1_valid_ff && $stable(s1_sample_ff)
         && $stable(s1_col_ff)))
      else $error("stage one lost its sample while stalled");
`endif

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 2x bilinear height grid upsampler.
// A short table of directed samples and register writes runs first. It covers
// the sample extremes, register clamping and a row length cut mid-frame.
// Random phases with random frame shapes follow. Every sample is fed to an
// internal model of the grid builder. Each result transaction is compared,
// field by field, with the oldest point that the model still holds. Both
// sides idle at random, and some phases run with no idling at all.
// ----------------------------------------------------------------------------
module tb;
   import hbu_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_SAMPLES = 400;
   localparam int STORE_DEPTH    = 128;

   typedef enum logic [1:0] {STEP_SAMPLE, STEP_CONFIG} step_kind_type;

   // one row of the directed table; pinned rows carry the sample's own point
   typedef struct packed {
      step_kind_type       kind;
      logic [15:0]         sample;
      logic [7:0]          len;
      logic [12:0]         rows;
      logic                pinned;
      logic [12:0]         pin_row;
      logic [7:0]          pin_col;
      logic [17:0]         pin_height;
   } directed_step_type;

   // one point of the upsampled grid
   typedef struct packed {
      logic [12:0] row;
      logic [7:0]  col;
      logic [17:0] height;
      logic        last;
   } grid_point_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;      // height_sample[15:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // out_row[12:0], out_col[20:13],
                                     // height_value[38:21], zero[39]
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [12:0] csr_wdata = '0;

   heightmap_bilinear_upsample_2x dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // grid builder model state
   logic [15:0] row_above [STORE_DEPTH];
   bit          row_above_written [STORE_DEPTH];
   logic [15:0] left_h = '0;
   logic [15:0] upleft_h = '0;
   int          col_pos = 0;
   int          row_pos = 0;
   logic [7:0]  cfg_row_length = 8'd101;
   logic [12:0] cfg_rows = 13'd101;

   grid_point_type pending_points [$];

   // pinned expectation for the sample in flight
   bit          pin_on = 1'b0;
   logic [12:0] pin_row;
   logic [7:0]  pin_col;
   logic [17:0] pin_height;

   bit idle_free = 1'b0;
   int stall_left = 0;
   int idle_cycles = 0;
   int mismatches = 0;
   int samples_taken = 0;
   int points_checked = 0;
   int csr_writes = 0;

   initial begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
         row_above[i] = '0;
         row_above_written[i] = 1'b0;
      end
   end

   function automatic int eff_row_len(input logic [7:0] v);
      if (v < 2) return 2;
      if (v > STORE_DEPTH) return STORE_DEPTH;
      return v;
   endfunction

   function automatic int eff_rows(input logic [12:0] v);
      if (v < 2) return 2;
      if (v > 4096) return 4096;
      return v;
   endfunction

   function automatic void push_point(input int row, input int col, input int h,
                                      input bit last);
      grid_point_type p;
      p.row = row[12:0];
      p.col = col[7:0];
      p.height = h[17:0];
      p.last = last;
      pending_points.push_back(p);
   endfunction

   // points caused by one sample, in delivery order, then advance the raster
   function automatic void predict_points(input logic [15:0] s);
      int c, r, cur, up, lft, ul;
      c = col_pos % STORE_DEPTH;
      r = row_pos;
      cur = $signed(s);
      up = $signed(row_above[c]);
      lft = $signed(left_h);
      ul = $signed(upleft_h);
      if (r > 0)
         push_point(2 * r - 1, 2 * c, 2 * (up + cur), 1'b0);
      if (r > 0 && c > 0)
         push_point(2 * r - 1, 2 * c - 1, ul + up + lft + cur, 1'b0);
      if (c > 0)
         push_point(2 * r, 2 * c - 1, 2 * (lft + cur), 1'b0);
      if (pin_on)
         push_point(pin_row, pin_col, $signed(pin_height), 1'b1);
      else
         push_point(2 * r, 2 * c, 4 * cur, 1'b1);

      upleft_h = row_above[c];
      row_above[c] = s;
      row_above_written[c] = 1'b1;
      left_h = s;
      if (c + 1 >= eff_row_len(cfg_row_length)) begin
         col_pos = 0;
         row_pos = (r + 1 >= eff_rows(cfg_rows)) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   task automatic report_field(input string field, input longint expv,
                               input longint gotv);
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, expv, gotv);
      mismatches++;
   endtask

   task automatic check_point();
      grid_point_type p;
      if (pending_points.size() == 0) begin
         $display("%0t: unexpected result transaction, tdata %h tlast %b",
                  $time, rsp_tdata, rsp_tlast);
         mismatches++;
      end else begin
         p = pending_points.pop_front();
         points_checked++;
         if (rsp_tdata[12:0] !== p.row)
            report_field("out_row", p.row, rsp_tdata[12:0]);
         if (rsp_tdata[20:13] !== p.col)
            report_field("out_col", p.col, rsp_tdata[20:13]);
         if (rsp_tdata[38:21] !== p.height)
            report_field("height_value", $signed(p.height), $signed(rsp_tdata[38:21]));
         if (rsp_tlast !== p.last)
            report_field("tlast", p.last, rsp_tlast);
         if (rsp_tdata[39] !== 1'b0)
            report_field("tdata pad bit", 0, rsp_tdata[39]);
      end
   endtask

   // transaction monitor, model update, result check and watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_ROW_LENGTH)
               cfg_row_length = csr_wdata[7:0];
            else
               cfg_rows = csr_wdata;
            csr_writes++;
         end
         if (req_tvalid && req_tready) begin
            predict_points(req_tdata);
            samples_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            check_point();
            stall_left = idle_free ? 0 : $urandom_range(0, 4);
         end
         if (csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, idle_cycles);
            $display("heightmap_bilinear_upsample_2x verification failed");
            $finish;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic int draw_gap();
      return idle_free ? 0 : $urandom_range(0, 4);
   endfunction

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_sample(input logic [15:0] s, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= s;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // write both registers once the block has drained
   task automatic write_config(input logic [7:0] len, input logic [12:0] rows);
      bit covered;
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(negedge clock);
      // a longer row mid-frame must not reach store entries never filled
      covered = 1'b1;
      for (int i = 0; i < eff_row_len(len); i++)
         if (!row_above_written[i]) covered = 1'b0;
      if (row_pos != 0 && !covered)
         len = cfg_row_length;
      csr_we <= 1'b1;
      csr_index <= CSR_ROW_LENGTH;
      csr_wdata <= {5'b0, len};
      @(negedge clock);
      csr_index <= CSR_ROWS_IN_FRAME;
      csr_wdata <= rows;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // directed table: extremes, clamping, mid-frame row cut, full small frames
   directed_step_type directed_steps [25] = '{
      '{STEP_SAMPLE, 16'h7FFF, 8'd0,   13'd0,    1'b1, 13'd0, 8'd0, 18'h1FFFC},
      '{STEP_SAMPLE, 16'h8000, 8'd0,   13'd0,    1'b1, 13'd0, 8'd2, 18'h20000},
      '{STEP_CONFIG, 16'h0000, 8'd2,   13'd2,    1'b0, 13'd0, 8'd0, 18'h00000},
      '{STEP_SAMPLE, 16'h8000, 8'd0,   13'd0,    1'b1, 13'd0, 8'd4, 18'h20000},
      '{STEP_SAMPLE, 16'h7FFF, 8'd0,   13'd0,    1'b1, 13'd2, 8'd0, 18'h1FFFC},
      '{STEP_SAMPLE, 16'h8000, 8'd0,   13'd0,    1'b1, 13'd2, 8'd2, 18'h20000},
      '{STEP_SAMPLE, 16'h8000, 8'd0,   13'd0,    1'b1, 13'd0, 8'd0, 18'h20000},
      '{STEP_SAMPLE, 16'h8000, 8'd0,   13'd0,    1'b0, 13'd0, 8'd0, 18'h00000},
      '{STEP_SAMPLE, 16'h8000, 8'd0,   13'd0,    1'b0, 13'd0, 8'd0, 18'h00000},
      '{STEP_SAMPLE, 16'h8000, 8'd0,   13'd0,    1'b1, 13'd2, 8'd2, 18'h20000},
      '{STEP_SAMPLE, 16'h7FFF, 8'd0,   13'd0,    1'b0, 13'd0, 8'd0, 18'h00000},
      '{STEP_SAMPLE, 16'h7FFF, 8'd0,   13'd0,    1'b0, 13'd0, 8'd0, 18'h00000},
      '{STEP_SAMPLE, 16'h7FFF, 8'd0,   13'd0,    1'b0, 13'd0, 8'd0, 18'h00000},
      '{STEP_SAMPLE, 16'h7FFF, 8'd0,   13'd0,    1'b1, 13'd2, 8'd2, 18'h1FFFC},
      '{STEP_CONFIG, 16'h0000, 8'd0,   13'd1,    1'b0, 13'd0, 8'd0, 18'h00000},
      '{STEP_SAMPLE, 16'h0000, 8'd0,   13'd0,    1'b1, 13'd0, 8'd0, 18'h00000},
      '{STEP_SAMPLE, 16'hFFFF, 8'd0,   13'd0,    1'b1, 13'd0, 8'd2, 18'h3FFFC},
      '{STEP_SAMPLE, 16'h0001, 8'd0,   13'd0,    1'b1, 13'd2, 8'd0, 18'h00004},
      '{STEP_SAMPLE, 16'h5555, 8'd0,   13'd0,    1'b1, 13'd2, 8'd2, 18'h15554},
      '{STEP_CONFIG, 16'h0000, 8'd255, 13'd8191, 1'b0, 13'd0, 8'd0, 18'h00000},
      '{STEP_SAMPLE, 16'hAAAA, 8'd0,   13'd0,    1'b1, 13'd0, 8'd0, 18'h2AAA8},
      '{STEP_SAMPLE, 16'h1234, 8'd0,   13'd0,    1'b0, 13'd0, 8'd0, 18'h00000},
      '{STEP_CONFIG, 16'h0000, 8'd128, 13'd4096, 1'b0, 13'd0, 8'd0, 18'h00000},
      '{STEP_SAMPLE, 16'h0F0F, 8'd0,   13'd0,    1'b0, 13'd0, 8'd0, 18'h00000},
      '{STEP_SAMPLE, 16'hF0F0, 8'd0,   13'd0,    1'b0, 13'd0, 8'd0, 18'h00000}
   };

   // stimulus sequence
   initial begin
      directed_step_type step;
      int random_sent;
      int burst_len;
      logic [7:0] len;
      logic [12:0] rows;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (directed_steps[i]) begin
         step = directed_steps[i];
         if (step.kind == STEP_CONFIG) begin
            write_config(step.len, step.rows);
         end else begin
            pin_on = step.pinned;
            pin_row = step.pin_row;
            pin_col = step.pin_col;
            pin_height = step.pin_height;
            send_sample(step.sample, draw_gap());
            pin_on = 1'b0;
         end
      end

      // one widest row and the start of the next, so every store entry is filled
      write_config(8'd128, 13'd2);
      random_sent = 0;
      repeat (140) begin
         send_sample(pick_sample(), draw_gap());
         random_sent++;
      end

      // random frame shapes, often cut mid-frame
      while (random_sent < RANDOM_SAMPLES) begin
         case ($urandom_range(0, 9))
            0: len = 8'($urandom_range(0, 1));
            1: len = 8'($urandom_range(129, 255));
            2: len = 8'd128;
            default: len = 8'($urandom_range(2, 8));
         endcase
         case ($urandom_range(0, 9))
            0: rows = 13'($urandom_range(0, 1));
            1: rows = 13'd4096;
            2: rows = 13'($urandom_range(4097, 8191));
            default: rows = 13'($urandom_range(2, 6));
         endcase
         write_config(len, rows);
         idle_free = ($urandom_range(0, 3) == 0);
         burst_len = $urandom_range(4, 30);
         repeat (burst_len) begin
            send_sample(pick_sample(), draw_gap());
            random_sent++;
         end
      end

      // drain, then give the block time to show any stray result
      req_tvalid <= 1'b0;
      while (pending_points.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      mismatches += pending_points.size();
      $display("run covered %0d samples, %0d grid points checked, %0d register writes",
               samples_taken, points_checked, csr_writes);
      $display("mismatches found: %0d", mismatches);
      if (mismatches == 0)
         $display("heightmap_bilinear_upsample_2x verification clean");
      else
         $display("heightmap_bilinear_upsample_2x verification failed");
      $finish;
   end

endmodule

[sim.f]
src/hbu_pkg.sv
src/hbu_ram.sv
src/hbu_emit.sv
src/heightmap_bilinear_upsample_2x.sv
tb/tb.sv
